/* src/mrtd_pkg.sv */
package mrtd_pkg;

    localparam int DEF_MAX_TASKS   = 16;
    localparam int DEF_PERIOD_BITS = 32;

    // fixed widths of the result fields
    localparam int MASK_W  = 16;
    localparam int SLOT_W  = 4;
    localparam int COUNT_W = 32;
    localparam int TASK_W  = 32;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_ADD  = 1'b1;

    // one bit of the tick counter travelling down the cell row, MSB first
    typedef struct packed {
        logic valid;
        logic first;
        logic last;
        logic data;
    } tick_beat_t;

endpackage

/* src/mrtd_cell.sv */
module mrtd_cell
    import mrtd_pkg::*;
#(
    parameter int PERIOD_BITS = DEF_PERIOD_BITS
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [PERIOD_BITS-1:0] wr_period,
    input  tick_beat_t             beat_in,
    output tick_beat_t             beat_out,
    output logic                   fire
);

    logic [PERIOD_BITS-1:0] period_reg;
    logic [PERIOD_BITS-1:0] rem_reg;
    logic [PERIOD_BITS-1:0] rem_next;
    logic                   fire_reg;
    tick_beat_t             beat_reg;
    logic [PERIOD_BITS:0]   shifted;
    logic [PERIOD_BITS:0]   diff;

    // one restoring-division step per beat: remainder of counter mod period
    always_comb
    begin
        if (beat_in.first)
        begin
            shifted = {{PERIOD_BITS{1'b0}}, beat_in.data};
        end
        else
        begin
            shifted = {rem_reg, beat_in.data};
        end
        diff = shifted - {1'b0, period_reg};
        if (shifted >= {1'b0, period_reg})
        begin
            rem_next = diff[PERIOD_BITS-1:0];
        end
        else
        begin
            rem_next = shifted[PERIOD_BITS-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            period_reg <= wr_period;
        end
        if (beat_in.valid)
        begin
            rem_reg <= rem_next;
        end
        if (beat_in.valid && beat_in.last)
        begin
            fire_reg <= (rem_next == '0) && (period_reg != '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            beat_reg <= '0;
        end
        else
        begin
            beat_reg <= beat_in;
        end
    end

    assign beat_out = beat_reg;
    assign fire     = fire_reg;

endmodule

/* src/multi_rate_tick_dispatcher_top.sv */
// Periodic task dispatcher.
//
// Input channel (in_valid/in_ready): one beat is either a tick (opcode 0) or
// an add-task request (opcode 1, task_period). Output channel
// (out_valid/out_ready): exactly one result beat per input beat, in order.
//
// Add-task: the period goes into the next free slot; once MAX_TASKS slots are
// taken the request is refused (accepted = 0).
// Tick: the counter is incremented, then its bits are streamed MSB first down
// a row of MAX_TASKS cells. Each cell holds one period and runs a bit-serial
// restoring division, one step per cycle, handing the bit to its neighbor.
// A tick ends once the last counter bit has left the last cell of the row.
// Periods of zero never fire. The counter returns to zero once it reaches
// the largest stored period.
//
// The block handles one item at a time; the result sits in an output
// register, so the next item is taken while the receiver stalls. Reset
// clears the counter, the task count and the largest-period register.
module multi_rate_tick_dispatcher_top
    import mrtd_pkg::*;
#(
    parameter int MAX_TASKS   = DEF_MAX_TASKS,
    parameter int PERIOD_BITS = DEF_PERIOD_BITS
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               opcode,
    input  logic [TASK_W-1:0]  task_period,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [MASK_W-1:0]  fire_mask,
    output logic [COUNT_W-1:0] tick_count,
    output logic               accepted,
    output logic [SLOT_W-1:0]  slot_index
);

    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int BIT_W = $clog2(PERIOD_BITS);

    // controller states
    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;  // streaming counter bits
    localparam logic [1:0] ST_DRAIN = 2'd2;  // waiting for the last cell
    localparam logic [1:0] ST_HOLD  = 2'd3;  // result ready, output busy

    logic [1:0]             state_reg,   state_next;
    logic [PERIOD_BITS-1:0] counter_reg, counter_next;
    logic [PERIOD_BITS-1:0] maxp_reg,    maxp_next;
    logic [CNT_W-1:0]       count_reg,   count_next;
    logic [BIT_W-1:0]       bit_reg,     bit_next;

    // pending result
    logic [MASK_W-1:0]      res_fire_reg, res_fire_next;
    logic                   res_acc_reg,  res_acc_next;
    logic [SLOT_W-1:0]      res_slot_reg, res_slot_next;

    // output register
    logic                   out_valid_reg;
    logic [MASK_W-1:0]      fire_mask_reg;
    logic [COUNT_W-1:0]     tick_count_reg;
    logic                   accepted_reg;
    logic [SLOT_W-1:0]      slot_index_reg;
    logic                   out_load;

    logic                   add_ok;
    logic [PERIOD_BITS-1:0] new_period;
    logic [31:0]            count_wide;
    tick_beat_t             src_beat;
    tick_beat_t             chain [MAX_TASKS+1];
    logic [MAX_TASKS-1:0]   fire_vec;
    logic [MASK_W-1:0]      cur_mask;

    assign new_period = PERIOD_BITS'(task_period);
    assign count_wide = 32'(count_reg);
    assign in_ready   = (state_reg == ST_IDLE);
    assign add_ok     = in_valid && in_ready && (opcode == OP_ADD)
                        && (count_reg < CNT_W'(MAX_TASKS));

    // counter bits, MSB first
    always_comb
    begin
        src_beat       = '0;
        src_beat.valid = (state_reg == ST_RUN);
        src_beat.first = (bit_reg == BIT_W'(PERIOD_BITS - 1));
        src_beat.last  = (bit_reg == '0);
        src_beat.data  = counter_reg[bit_reg];
    end

    assign chain[0] = src_beat;

    genvar gi;
    generate
        for (gi = 0; gi < MAX_TASKS; gi++)
        begin : g_cell
            mrtd_cell #(
                .PERIOD_BITS (PERIOD_BITS)
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .wr_en     (add_ok && (count_reg == CNT_W'(gi))),
                .wr_period (new_period),
                .beat_in   (chain[gi]),
                .beat_out  (chain[gi+1]),
                .fire      (fire_vec[gi])
            );
        end

        // slots beyond the stored count are masked; only the low 16 are reported
        for (gi = 0; gi < MASK_W; gi++)
        begin : g_mask
            if (gi < MAX_TASKS)
            begin : g_live
                assign cur_mask[gi] = fire_vec[gi] && (count_reg > CNT_W'(gi));
            end
            else
            begin : g_none
                assign cur_mask[gi] = 1'b0;
            end
        end
    endgenerate

    assign out_load = (state_reg == ST_HOLD) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next    = state_reg;
        counter_next  = counter_reg;
        maxp_next     = maxp_reg;
        count_next    = count_reg;
        bit_next      = bit_reg;
        res_fire_next = res_fire_reg;
        res_acc_next  = res_acc_reg;
        res_slot_next = res_slot_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (opcode == OP_ADD)
                    begin
                        res_fire_next = '0;
                        if (add_ok)
                        begin
                            count_next    = count_reg + CNT_W'(1);
                            res_acc_next  = 1'b1;
                            res_slot_next = count_wide[SLOT_W-1:0];
                            if (new_period > maxp_reg)
                            begin
                                maxp_next = new_period;
                            end
                        end
                        else
                        begin
                            res_acc_next  = 1'b0;
                            res_slot_next = '0;
                        end
                        state_next = ST_HOLD;
                    end
                    else
                    begin
                        counter_next = counter_reg + PERIOD_BITS'(1);
                        bit_next     = BIT_W'(PERIOD_BITS - 1);
                        state_next   = ST_RUN;
                    end
                end
            end
            ST_RUN:
            begin
                bit_next = bit_reg - BIT_W'(1);
                if (bit_reg == '0)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (chain[MAX_TASKS].valid && chain[MAX_TASKS].last)
                begin
                    res_fire_next = cur_mask;
                    res_acc_next  = 1'b1;
                    res_slot_next = '0;
                    if (counter_reg >= maxp_reg)
                    begin
                        counter_next = '0;
                    end
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            counter_reg   <= '0;
            maxp_reg      <= '0;
            count_reg     <= '0;
            bit_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            counter_reg <= counter_next;
            maxp_reg    <= maxp_next;
            count_reg   <= count_next;
            bit_reg     <= bit_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        res_fire_reg <= res_fire_next;
        res_acc_reg  <= res_acc_next;
        res_slot_reg <= res_slot_next;
        if (out_load)
        begin
            fire_mask_reg  <= res_fire_reg;
            tick_count_reg <= COUNT_W'(counter_reg);
            accepted_reg   <= res_acc_reg;
            slot_index_reg <= res_slot_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign fire_mask  = fire_mask_reg;
    assign tick_count = tick_count_reg;
    assign accepted   = accepted_reg;
    assign slot_index = slot_index_reg;

endmodule

/* tb/tb_multi_rate_tick_dispatcher_top.sv */
`timescale 1ns / 1ps

// Self-checking bench for the periodic task dispatcher.
// Directed rows first, then random ticks and add requests with random gaps on
// both channels. Each result beat is checked against a typed row or the predictor.
module tb_multi_rate_tick_dispatcher_top;
    import mrtd_pkg::*;

    localparam int N_SLOTS     = DEF_MAX_TASKS;
    localparam int P_BITS      = DEF_PERIOD_BITS;
    localparam int RAND_ITEMS  = 1200;
    localparam int N_DIRECTED  = 14;
    // drain window after the last due beat, longer than the worst tick
    localparam int DRAIN_CYC   = 64;
    // slowest run: all ticks with the longest gaps on both sides, plus one long hold-off
    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYC    = 400;  // long receiver hold-off
    localparam int HOLD_AFTER  = 200;  // beats checked before the hold-off

    // one result beat
    typedef struct packed {
        logic [MASK_W-1:0]  mask;
        logic [COUNT_W-1:0] count;
        logic               acc;
        logic [SLOT_W-1:0]  slot;
    } dispatch_res_t;

    // one directed row; typed = 1 means res holds a hand-written expectation
    typedef struct packed {
        logic              op;
        logic [TASK_W-1:0] per;
        logic              typed;
        dispatch_res_t     res;
    } stim_row_t;

    logic               clk;
    logic               rst_n       = 1'b0;
    logic               in_valid    = 1'b0;
    logic               in_ready;
    logic               opcode      = OP_TICK;
    logic [TASK_W-1:0]  task_period = '0;
    logic               out_valid;
    logic               out_ready   = 1'b0;
    logic [MASK_W-1:0]  fire_mask;
    logic [COUNT_W-1:0] tick_count;
    logic               accepted;
    logic [SLOT_W-1:0]  slot_index;

    // predictor state
    logic [P_BITS-1:0]  tick_ctr;
    int                 task_cnt;
    logic [P_BITS-1:0]  period_slot [N_SLOTS];

    dispatch_res_t      due_results [$];
    stim_row_t          directed_rows [N_DIRECTED];

    int                 errors       = 0;
    int                 beats_seen   = 0;
    int                 cycles       = 0;
    int                 adds_sent    = 0;
    int                 adds_refused = 0;
    int                 ticks_sent   = 0;
    int                 fired_ticks  = 0;
    int                 wraps_seen   = 0;
    bit                 send_burst   = 1'b0;
    bit                 recv_burst   = 1'b0;
    bit                 hold_done    = 1'b0;

    multi_rate_tick_dispatcher_top dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .task_period (task_period),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .fire_mask   (fire_mask),
        .tick_count  (tick_count),
        .accepted    (accepted),
        .slot_index  (slot_index)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Watchdog: a hung handshake or a lost beat ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d results still due",
                     $time, cycles, due_results.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Predictor: advances its own copy of the dispatcher state by one beat
    // and returns the result that beat must produce.
    function automatic dispatch_res_t dispatch_step(input logic op,
                                                    input logic [TASK_W-1:0] per);
        dispatch_res_t     r;
        logic [P_BITS-1:0] top_period;
        r          = '0;
        r.acc      = 1'b1;
        top_period = '0;
        if (op == OP_ADD)
        begin
            if (task_cnt < N_SLOTS)
            begin
                period_slot[task_cnt] = per[P_BITS-1:0];
                r.slot   = SLOT_W'(task_cnt);
                task_cnt = task_cnt + 1;
            end
            else
            begin
                r.acc = 1'b0;  // table full, nothing changes
            end
        end
        else
        begin
            tick_ctr = tick_ctr + P_BITS'(1);
            for (int i = 0; i < task_cnt; i++)
            begin
                if (period_slot[i] > top_period)
                    top_period = period_slot[i];
                // zero period is stored but never fires
                if (period_slot[i] != '0 && (tick_ctr % period_slot[i]) == '0)
                    r.mask[i] = 1'b1;
            end
            // wrap once the counter reaches the largest stored period
            if (tick_ctr >= top_period)
                tick_ctr = '0;
        end
        r.count = COUNT_W'(tick_ctr);
        return r;
    endfunction

    // Offer one input beat after a random gap, hold it until taken, and
    // return what the predictor says it must produce.
    task automatic offer_item(input logic op, input logic [TASK_W-1:0] per,
                              output dispatch_res_t pred);
        int gap;
        if ($urandom_range(0, 63) == 0)
            send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 13);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        opcode      <= op;
        task_period <= per;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        // beat taken at this edge
        pred = dispatch_step(op, per);
        if (op == OP_ADD)
        begin
            adds_sent = adds_sent + 1;
            if (!pred.acc)
                adds_refused = adds_refused + 1;
        end
        else
        begin
            ticks_sent = ticks_sent + 1;
            if (pred.mask != '0)
                fired_ticks = fired_ticks + 1;
            if (pred.count == '0)
                wraps_seen = wraps_seen + 1;
        end
    endtask

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got)
        begin
            errors = errors + 1;
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, name, want, got);
        end
    endtask

    // Receiver: random ready gaps, burst stretches, and one long hold-off
    // while the sender keeps pushing so the block backs up into in_ready.
    initial
    begin : result_side
        int            gap;
        dispatch_res_t want;
        wait (rst_n);
        forever
        begin
            if ($urandom_range(0, 63) == 0)
                recv_burst = !recv_burst;
            gap = recv_burst ? 0 : $urandom_range(0, 13);
            if (!hold_done && beats_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                gap = HOLD_CYC;
            end
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            beats_seen = beats_seen + 1;
            if (due_results.size() == 0)
            begin
                errors = errors + 1;
                $display("%0t: result beat with nothing due, actual mask %0h count %0h",
                         $time, fire_mask, tick_count);
            end
            else
            begin
                want = due_results.pop_front();
                check_field("fire_mask",  64'(want.mask),  64'(fire_mask));
                check_field("tick_count", 64'(want.count), 64'(tick_count));
                check_field("accepted",   64'(want.acc),   64'(accepted));
                check_field("slot_index", 64'(want.slot),  64'(slot_index));
            end
        end
    end

    initial
    begin : stimulus
        dispatch_res_t     pred;
        logic              op;
        logic [TASK_W-1:0] per;

        tick_ctr = '0;
        task_cnt = 0;
        for (int i = 0; i < N_SLOTS; i++)
            period_slot[i] = '0;

        // Directed rows. Expectations typed only where obvious:
        // empty table, zero period, period 3 counting up and wrapping.
        //                     op       period        typed  mask     count  acc   slot
        directed_rows[0]  = '{OP_TICK, 32'hFFFF_FFFF, 1'b1, '{16'h0000, 32'd0, 1'b1, 4'd0}};
        directed_rows[1]  = '{OP_ADD,  32'h0000_0000, 1'b1, '{16'h0000, 32'd0, 1'b1, 4'd0}};
        directed_rows[2]  = '{OP_TICK, 32'h0000_0000, 1'b1, '{16'h0000, 32'd0, 1'b1, 4'd0}};
        directed_rows[3]  = '{OP_ADD,  32'h0000_0003, 1'b1, '{16'h0000, 32'd0, 1'b1, 4'd1}};
        directed_rows[4]  = '{OP_TICK, 32'h5555_5555, 1'b1, '{16'h0000, 32'd1, 1'b1, 4'd0}};
        directed_rows[5]  = '{OP_TICK, 32'hAAAA_AAAA, 1'b1, '{16'h0000, 32'd2, 1'b1, 4'd0}};
        directed_rows[6]  = '{OP_TICK, 32'h0000_0000, 1'b1, '{16'h0002, 32'd0, 1'b1, 4'd0}};
        directed_rows[7]  = '{OP_ADD,  32'h0000_0002, 1'b1, '{16'h0000, 32'd0, 1'b1, 4'd2}};
        directed_rows[8]  = '{OP_TICK, 32'h0000_0000, 1'b0, '0};
        directed_rows[9]  = '{OP_TICK, 32'hFFFF_FFFF, 1'b0, '0};
        directed_rows[10] = '{OP_TICK, 32'h0000_0000, 1'b0, '0};
        directed_rows[11] = '{OP_ADD,  32'h0000_0001, 1'b0, '0};
        directed_rows[12] = '{OP_TICK, 32'h0000_0000, 1'b0, '0};
        directed_rows[13] = '{OP_TICK, 32'h0000_0000, 1'b0, '0};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int r = 0; r < N_DIRECTED; r++)
        begin
            offer_item(directed_rows[r].op, directed_rows[r].per, pred);
            if (directed_rows[r].typed)
                due_results.push_back(directed_rows[r].res);
            else
                due_results.push_back(pred);
        end

        // Random part: mostly ticks. Adds fill the table with small periods so
        // the counter keeps wrapping; once full, adds carry wide and extreme
        // periods and must be refused. Ticks carry random junk in task_period.
        for (int n = 0; n < RAND_ITEMS; n++)
        begin
            op = ($urandom_range(0, 7) == 0) ? OP_ADD : OP_TICK;
            if (op == OP_ADD && adds_sent < N_SLOTS)
            begin
                if ($urandom_range(0, 11) == 0)
                    per = '0;
                else if ($urandom_range(0, 7) == 0)
                    per = TASK_W'($urandom_range(49, 300));
                else
                    per = TASK_W'($urandom_range(1, 48));
            end
            else
            begin
                case ($urandom_range(0, 3))
                    0:       per = '0;
                    1:       per = '1;
                    default: per = $urandom;
                endcase
            end
            offer_item(op, per, pred);
            due_results.push_back(pred);
        end
        in_valid <= 1'b0;

        while (due_results.size() != 0)
            @(posedge clk);
        // stray beats after the last expected one get caught by the receiver
        repeat (DRAIN_CYC) @(posedge clk);

        $display("Covered %0d ticks (%0d with fires, %0d ending at zero), %0d adds (%0d refused).",
                 ticks_sent, fired_ticks, wraps_seen, adds_sent, adds_refused);
        $display("Checked %0d result beats with one %0d-cycle receiver hold-off, %0d errors.",
                 beats_seen, HOLD_CYC, errors);
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
